FILE: sv/lkv_pkg.sv
// Package with shared types and constants of the LRU key/value cache.
`timescale 1ns / 1ps

package lkv_pkg;

	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int CAP_W       = 5;
	localparam int ENTRIES_DEF = 16;

	localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	// Command codes
	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_SET = 1'b1;

	// One stored entry as it moves down the cell chain
	typedef struct packed {
		logic                    valid;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} lkv_entry_t;

	// Per-cell control from the sequencer
	typedef struct packed {
		logic cmp;   // register the key match
		logic shift; // take the upstream entry
		logic keep;  // upstream entry stays live after the shift
	} lkv_cell_ctrl_t;

endpackage

FILE: sv/lkv_if.sv
// Handshake interfaces for request, response and configuration transactions.
`timescale 1ns / 1ps

interface lkv_req_if import lkv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    cmd;
	logic signed [KEY_W-1:0] lookup_key;
	logic signed [VAL_W-1:0] store_value;

	modport source (output valid, cmd, lookup_key, store_value, input ready);
	modport sink (input valid, cmd, lookup_key, store_value, output ready);
endinterface

interface lkv_rsp_if import lkv_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    hit;
	logic signed [VAL_W-1:0] read_value;

	modport source (output valid, hit, read_value, input ready);
	modport sink (input valid, hit, read_value, output ready);
endinterface

interface lkv_cfg_if import lkv_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CAP_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: sv/lkv_cell.sv
// One cell of the recency chain: holds the entry of one recency rank.
`timescale 1ns / 1ps

module lkv_cell import lkv_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lkv_cell_ctrl_t          ctrl,
	input  logic signed [KEY_W-1:0] req_key,
	input  lkv_entry_t              up,
	output lkv_entry_t              ent,
	output logic                    match_q,
	output logic [VAL_W-1:0]        mval_q
);

	logic                    valid_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [VAL_W-1:0] value_q;
	logic                    match;

	assign match = valid_q && (key_q == req_key);

	// Valid bit and match flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctrl.shift) begin
				valid_q <= up.valid && ctrl.keep;
			end
			if (ctrl.cmp) begin
				match_q <= match;
			end
		end
	end

	// Payload: take the neighbor's entry on a shift, mask value on compare
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q   <= up.key;
			value_q <= up.value;
		end
		if (ctrl.cmp) begin
			mval_q <= match ? value_q : '0;
		end
	end

	assign ent.valid = valid_q;
	assign ent.key   = key_q;
	assign ent.value = value_q;

endmodule

FILE: sv/lru_key_value_cache.sv
// LRU key/value cache: sequencer and a chain of cells ordered by recency.
// A get result is registered after the compare and update steps of its request.
// Each request has a compare step to broadcast the key compare over all cells and an
// update step to move the chain down by a cell or read the hit, taking the next request.
// A set gives no response; a get waits in its update cycle while a response is held.
// Reset clears all valid bits at once and sets capacity to 16; no clearing pass.
`timescale 1ns / 1ps

module lru_key_value_cache import lkv_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input logic   clk,
	input logic   arst_n,
	lkv_cfg_if.sink   cfg,
	lkv_req_if.sink   req,
	lkv_rsp_if.source rsp
);

	localparam int IDXW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int LIM_W = (IDXW + 1 > CAP_W) ? IDXW + 1 : CAP_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	logic [1:0]              state_q;
	logic [CAP_W-1:0]        cap_q;
	logic                    cmd_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [VAL_W-1:0] val_q;
	logic                    rsp_valid_q;
	logic                    rsp_hit_q;
	logic [VAL_W-1:0]        rsp_value_q;

	logic                    req_take;
	logic                    upd_go;
	logic                    hit_any;
	logic [LIM_W-1:0]        cap_ext;
	logic [LIM_W-1:0]        eff_cap;
	logic [LIM_W-1:0]        limit;
	logic [ENTRIES-1:0]      match_vec;
	logic [ENTRIES-1:0]      valid_vec;
	logic [ENTRIES-1:0]      keep_vec;
	logic [ENTRIES-1:0]      sfx [0:IDXW];
	logic [VAL_W-1:0]        vor [0:IDXW][0:ENTRIES-1];
	logic [VAL_W-1:0]        mval [0:ENTRIES-1];
	lkv_entry_t              ent [0:ENTRIES-1];
	lkv_entry_t              up [0:ENTRIES-1];
	lkv_cell_ctrl_t          cctl [0:ENTRIES-1];

	// Configuration: always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.data;
		end
	end

	// Clamp capacity to 1..ENTRIES; entries at rank limit or beyond drop on insert
	assign cap_ext = LIM_W'(cap_q);
	assign eff_cap = (cap_q == '0) ? LIM_W'(1) :
		((cap_ext > LIM_W'(ENTRIES)) ? LIM_W'(ENTRIES) : cap_ext);
	assign limit   = eff_cap - LIM_W'(1);

	// Handshake
	assign upd_go   = (state_q == ST_UPD) &&
		((cmd_q == CMD_SET) || !rsp_valid_q || rsp.ready);
	assign req.ready = (state_q == ST_IDLE) || upd_go;
	assign req_take  = req.valid && req.ready;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) state_q <= ST_CMP;
				end
				ST_CMP: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (upd_go) state_q <= req_take ? ST_CMP : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the request under work
	always_ff @(posedge clk) begin
		if (req_take) begin
			cmd_q <= req.cmd;
			key_q <= req.lookup_key;
			val_q <= req.store_value;
		end
	end

	// Suffix OR of matches and OR of masked values, log-depth prefix network
	always_comb begin
		sfx[0] = match_vec;
		for (int i = 0; i < ENTRIES; i++) begin
			vor[0][i] = mval[i];
		end
		for (int d = 0; d < IDXW; d++) begin
			sfx[d+1] = sfx[d];
			for (int i = 0; i < ENTRIES; i++) begin
				vor[d+1][i] = vor[d][i];
				if (i + (1 << d) < ENTRIES) begin
					sfx[d+1][i]  = sfx[d][i] | sfx[d][i + (1 << d)];
					vor[d+1][i] = vor[d][i] | vor[d][i + (1 << d)];
				end
			end
		end
	end

	assign hit_any = sfx[IDXW][0];

	// Cell chain; cell 0 takes the request entry
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign up[g].valid = 1'b1;
			assign up[g].key   = key_q;
			assign up[g].value = val_q;
		end else begin : g_body
			assign up[g] = ent[g-1];
		end

		assign keep_vec[g]     = (g == 0) || hit_any || (LIM_W'(g) <= limit);
		assign cctl[g].cmp     = (state_q == ST_CMP);
		assign cctl[g].shift   = upd_go && (cmd_q == CMD_SET) &&
			(!hit_any || sfx[IDXW][g]);
		assign cctl[g].keep    = keep_vec[g];
		assign valid_vec[g]    = ent[g].valid;

		lkv_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (cctl[g]),
			.req_key (key_q),
			.up      (up[g]),
			.ent     (ent[g]),
			.match_q (match_vec[g]),
			.mval_q  (mval[g])
		);
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (upd_go && (cmd_q == CMD_GET)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go && (cmd_q == CMD_GET)) begin
			rsp_hit_q   <= hit_any;
			rsp_value_q <= hit_any ? vor[IDXW][0] : MISS_VALUE;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = rsp_hit_q;
	assign rsp.read_value = rsp_value_q;

	// Keys are unique among live cells
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPD) |-> $onehot0(match_vec))
		else $error("more than one cell matches the key");

	// Live cells form an unbroken run from the head of the chain
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		((ENTRIES'(valid_vec + ENTRIES'(1)) & valid_vec) == '0))
		else $error("gap in live cells");

	// A completed set leaves the head cell live
	a_head_live: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && (cmd_q == CMD_SET)) |=> valid_vec[0])
		else $error("head cell not live after set");

	// A response appears only after the update cycle of a get
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(upd_go && (cmd_q == CMD_GET)))
		else $error("response without get");

endmodule
